>>> rtl/core/i2c_master_bit_engine_assert.svh
// Assertion macros shared by the I2C master bit engine RTL.
`ifndef I2C_MASTER_BIT_ENGINE_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define I2CM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define I2CM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/i2cm_pkg.sv
// Shared types and constants for the I2C master bit engine.
package i2cm_pkg;

    localparam logic [2:0] OP_START = 3'd0;
    localparam logic [2:0] OP_STOP  = 3'd1;
    localparam logic [2:0] OP_WRITE = 3'd2;
    localparam logic [2:0] OP_READ  = 3'd3;
    localparam logic [2:0] OP_SACK  = 3'd4;
    localparam logic [2:0] OP_RACK  = 3'd5;

    localparam logic [7:0] HALF_PERIOD_RESET = 8'd10;
    localparam logic [3:0] BITS_PER_BYTE     = 4'd8;

    localparam int QUEUE_DEPTH = 2;
    localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 4;
    localparam int OUT_DATA_W = 16;

    // result item bit positions in m_tdata
    localparam int OUT_SCL_BIT  = 0;
    localparam int OUT_SDA_BIT  = 1;
    localparam int OUT_BUSY_BIT = 2;
    localparam int OUT_DONE_BIT = 3;
    localparam int OUT_RX_LSB   = 4;
    localparam int OUT_ACK_BIT  = 12;

    // one classified tick as held in the queue
    typedef struct packed {
        logic       go;
        logic [2:0] op;
        logic [7:0] tx_byte;
        logic       ack_to_send;
        logic       sda_in;
    } tick_t;

    typedef struct packed {
        logic               full;
        logic               empty;
        logic [LEVEL_W-1:0] level;
    } q_status_t;

endpackage

>>> rtl/core/i2cm_front.sv
// Input side: takes tick items and classifies the command they carry.
module i2cm_front
(
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [i2cm_pkg::IN_DATA_W-1:0]   s_tdata,  // tx_byte[7:0], ack_to_send[8], sda_in[9]
    input  logic [i2cm_pkg::IN_USER_W-1:0]   s_tuser,  // cmd_valid[0], op[3:1]
    input  i2cm_pkg::q_status_t              q_stat,
    output logic                             q_push,
    output i2cm_pkg::tick_t                  q_entry
);
    import i2cm_pkg::*;

    logic [2:0] op;

    assign op       = s_tuser[3:1];
    assign s_tready = !q_stat.full;
    assign q_push   = s_tvalid && !q_stat.full;

    always_comb
    begin
        q_entry.op          = op;
        // codes past receive ack are dropped here so the engine stays idle
        q_entry.go          = s_tuser[0] && (op inside {[OP_START:OP_RACK]});
        q_entry.tx_byte     = s_tdata[7:0];
        q_entry.ack_to_send = s_tdata[8];
        q_entry.sda_in      = s_tdata[9];
    end

endmodule

>>> rtl/core/i2cm_queue.sv
// Short queue of classified ticks between front and back.
module i2cm_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  i2cm_pkg::tick_t     push_entry,
    input  logic                pop,
    output i2cm_pkg::tick_t     head,
    output i2cm_pkg::q_status_t stat
);
    import i2cm_pkg::*;

    tick_t              mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [LEVEL_W-1:0] level_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            level_next = level_reg + LEVEL_W'(1);
        end
        else if (pop && !push)
        begin
            level_next = level_reg - LEVEL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    assign head       = mem[rd_ptr_reg];
    assign stat.level = level_reg;
    assign stat.empty = (level_reg == '0);
    assign stat.full  = (level_reg == LEVEL_W'(QUEUE_DEPTH));

endmodule

>>> rtl/core/i2cm_back.sv
// Bus sequencer: advances SCL/SDA one tick per queued item, registers the result.
module i2cm_back
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [7:0]                       half_period_ticks,
    input  i2cm_pkg::tick_t                  head,
    input  i2cm_pkg::q_status_t              q_stat,
    output logic                             pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [i2cm_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import i2cm_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_FIRST,
        PH_SECOND,
        PH_HIGH,
        PH_LOW
    } phase_t;

    phase_t     phase_reg,  phase_next;
    logic [2:0] op_reg,     op_next;
    logic [3:0] bits_reg,   bits_next;
    logic [7:0] shift_reg,  shift_next;
    logic [7:0] delay_reg,  delay_next;
    logic       scl_reg,    scl_next;
    logic       sda_reg,    sda_next;
    logic       ack_reg,    ack_next;
    logic [7:0] rx_reg,     rx_next;
    logic       out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic       fire;
    logic       done;
    logic [7:0] seg_len;
    logic [7:0] delay_dec;
    logic [3:0] bits_inc;
    logic [OUT_DATA_W-1:0] result;

    assign fire      = !q_stat.empty && (!out_valid_reg || m_tready);
    assign pop       = fire;
    assign seg_len   = (half_period_ticks == 8'd0) ? 8'd1 : half_period_ticks;
    assign delay_dec = delay_reg - 8'd1;
    assign bits_inc  = bits_reg + 4'd1;

    always_comb
    begin
        phase_next = phase_reg;
        op_next    = op_reg;
        bits_next  = bits_reg;
        shift_next = shift_reg;
        delay_next = delay_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        ack_next   = ack_reg;
        rx_next    = rx_reg;
        done       = 1'b0;

        case (phase_reg)
            PH_IDLE:
            begin
                if (head.go)
                begin
                    op_next    = head.op;
                    bits_next  = '0;
                    delay_next = seg_len;
                    scl_next   = 1'b1;
                    phase_next = PH_HIGH;
                    sda_next   = 1'b1;
                    case (head.op)
                        OP_START: phase_next = PH_FIRST;
                        OP_STOP:
                        begin
                            phase_next = PH_FIRST;
                            sda_next   = 1'b0;
                        end
                        OP_WRITE:
                        begin
                            sda_next   = head.tx_byte[7];
                            shift_next = {head.tx_byte[6:0], 1'b0};
                        end
                        OP_READ:  shift_next = '0;
                        OP_SACK:  sda_next   = head.ack_to_send;
                        default:  sda_next   = 1'b1;
                    endcase
                end
            end
            PH_FIRST, PH_SECOND, PH_HIGH, PH_LOW:
            begin
                delay_next = delay_dec;
                if (delay_dec == 8'd0)
                begin
                    case (phase_reg)
                        PH_FIRST:
                        begin
                            phase_next = PH_SECOND;
                            scl_next   = 1'b1;
                            sda_next   = (op_reg != OP_START);
                            delay_next = seg_len;
                        end
                        PH_SECOND:
                        begin
                            if (op_reg == OP_START)
                            begin
                                scl_next = 1'b0;
                            end
                            done = 1'b1;
                        end
                        PH_HIGH:
                        begin
                            // ack clock of a write, after the last data bit: sample the ack and finish
                            if (op_reg == OP_WRITE && bits_reg >= BITS_PER_BYTE)
                            begin
                                ack_next = head.sda_in;
                                scl_next = 1'b0;
                                done     = 1'b1;
                            end
                            else
                            begin
                                if (op_reg == OP_READ)
                                begin
                                    shift_next = {shift_reg[6:0], head.sda_in};
                                end
                                if (op_reg == OP_RACK)
                                begin
                                    ack_next = head.sda_in;
                                end
                                phase_next = PH_LOW;
                                scl_next   = 1'b0;
                                delay_next = seg_len;
                            end
                        end
                        PH_LOW:
                        begin
                            if (op_reg == OP_WRITE)
                            begin
                                bits_next  = bits_inc;
                                phase_next = PH_HIGH;
                                scl_next   = 1'b1;
                                delay_next = seg_len;
                                if (bits_inc < BITS_PER_BYTE)
                                begin
                                    sda_next   = shift_reg[7];
                                    shift_next = {shift_reg[6:0], 1'b0};
                                end
                                else
                                begin
                                    sda_next = 1'b1;
                                end
                            end
                            else if (op_reg == OP_READ)
                            begin
                                bits_next = bits_inc;
                                if (bits_inc < BITS_PER_BYTE)
                                begin
                                    phase_next = PH_HIGH;
                                    scl_next   = 1'b1;
                                    sda_next   = 1'b1;
                                    delay_next = seg_len;
                                end
                                else
                                begin
                                    rx_next = shift_reg;
                                    done    = 1'b1;
                                end
                            end
                            else
                            begin
                                done = 1'b1;
                            end
                        end
                        default: done = 1'b1;
                    endcase
                    if (done)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    always_comb
    begin
        result                          = '0;
        result[OUT_SCL_BIT]             = scl_next;
        result[OUT_SDA_BIT]             = sda_next;
        result[OUT_BUSY_BIT]            = (phase_next != PH_IDLE);
        result[OUT_DONE_BIT]            = done;
        result[OUT_RX_LSB +: 8]         = rx_next;
        result[OUT_ACK_BIT]             = ack_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            op_reg        <= '0;
            bits_reg      <= '0;
            shift_reg     <= '0;
            delay_reg     <= '0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            ack_reg       <= 1'b1;
            rx_reg        <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (fire)
            begin
                phase_reg     <= phase_next;
                op_reg        <= op_next;
                bits_reg      <= bits_next;
                shift_reg     <= shift_next;
                delay_reg     <= delay_next;
                scl_reg       <= scl_next;
                sda_reg       <= sda_next;
                ack_reg       <= ack_next;
                rx_reg        <= rx_next;
                out_data_reg  <= result;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

>>> rtl/core/i2c_master_bit_engine.sv
// Top level of the I2C master bit engine: front, tick queue, bus sequencer.
//
//  channel   | direction | handshake          | payload
//  s_        | in        | s_tvalid/s_tready  | s_tdata tick fields, s_tuser command
//  m_        | out       | m_tvalid/m_tready  | m_tdata bus levels and status
//  cfg_      | in        | cfg_valid/cfg_ready| cfg_data half_period_ticks
//
// One result item per tick item; the sequencer takes one item per cycle, so
// throughput is one item per clock with no stalls downstream.
// The tick is written into the queue at its accepting edge, and the sequencer registers
// its result when it pops that entry from the queue.
// Reset idles the bus (SCL and SDA released) and sets half_period_ticks to 10.
// A stalled output holds the sequencer; the two-entry queue then fills and
// drops s_tready.
module i2c_master_bit_engine
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [i2cm_pkg::IN_DATA_W-1:0]   s_tdata,  // tx_byte[7:0], ack_to_send[8], sda_in[9]
    input  logic [i2cm_pkg::IN_USER_W-1:0]   s_tuser,  // cmd_valid[0], op[3:1]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // scl_level[0], sda_release[1], busy_res[2], done_res[3], rx_byte[11:4], rx_ack[12]
    output logic [i2cm_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [7:0]                       cfg_data
);
    import i2cm_pkg::*;

    `include "i2c_master_bit_engine_assert.svh"

    logic       q_push;
    logic       q_pop;
    tick_t      q_entry;
    tick_t      q_head;
    q_status_t  q_stat;
    logic [7:0] half_period_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= HALF_PERIOD_RESET;
        end
        else if (cfg_valid)
        begin
            half_period_reg <= cfg_data;
        end
    end

    i2cm_front u_front
    (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    i2cm_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .stat       (q_stat)
    );

    i2cm_back u_back
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .half_period_ticks (half_period_reg),
        .head              (q_head),
        .q_stat            (q_stat),
        .pop               (q_pop),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata)
    );

    `I2CM_ASSERT_NOW(a_level_bound, 1'b1, q_stat.level <= LEVEL_W'(QUEUE_DEPTH), "queue overfilled")
    `I2CM_ASSERT_NOW(a_done_not_busy, m_tvalid && m_tdata[OUT_DONE_BIT], !m_tdata[OUT_BUSY_BIT], "done while busy")
    `I2CM_ASSERT_NXT(a_push_grows, q_push && !q_pop, q_stat.level == $past(q_stat.level) + LEVEL_W'(1), "queue level lost a push")
    `I2CM_ASSERT_NOW(a_pop_nonempty, q_pop, !q_stat.empty, "pop from empty queue")

endmodule

>>> tb/i2c_master_bit_engine_tb.sv
// Testbench for the I2C master bit engine: bus predictor class, stream drivers and checks.
`timescale 1ns / 100ps

module i2c_master_bit_engine_tb;

    import i2cm_pkg::*;

    // op codes the engine must ignore
    localparam logic [2:0] OP_BAD_LO = 3'd6;
    localparam logic [2:0] OP_BAD_HI = 3'd7;

    typedef enum logic [3:0] {SEG_IDLE, SEG_FIRST, SEG_SECOND, SEG_HIGH, SEG_LOW} seg_t;
    typedef enum int {SDA_LOW, SDA_HIGH, SDA_RANDOM} sda_mode_t;

    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] op;
        logic [7:0] tx_byte;
        logic       ack_to_send;
        logic       sda_in;
    } bus_tick_t;

    typedef struct packed {
        logic       scl;
        logic       sda_rel;
        logic       busy;
        logic       done;
        logic [7:0] rx_byte;
        logic       rx_ack;
    } bus_levels_t;

    // Tracks the bus sequencer and holds the bus levels still to come out.
    class bus_scoreboard;
        logic [7:0]  half_period;
        seg_t        seg;
        logic [2:0]  cur_op;
        logic [3:0]  bit_cnt;
        logic [7:0]  shreg;
        logic [7:0]  dcount;
        logic        scl;
        logic        sda;
        logic        ack;
        logic [7:0]  rx_hold;
        bus_levels_t levels_q[$];
        int          failures;

        function new();
            half_period = HALF_PERIOD_RESET;
            seg         = SEG_IDLE;
            cur_op      = OP_START;
            bit_cnt     = '0;
            shreg       = '0;
            dcount      = '0;
            scl         = 1'b1;
            sda         = 1'b1;
            ack         = 1'b1;
            rx_hold     = '0;
            failures    = 0;
        endfunction

        function bit is_idle();
            return seg == SEG_IDLE;
        endfunction

        function int pending();
            return levels_q.size();
        endfunction

        function void load_segment(seg_t s, logic c, logic d);
            seg    = s;
            scl    = c;
            sda    = d;
            dcount = (half_period == 8'd0) ? 8'd1 : half_period;
        endfunction

        // end of a bus segment; 1 when the command completes
        function bit close_segment(logic sda_in);
            case (seg)
                SEG_FIRST:
                begin
                    load_segment(SEG_SECOND, 1'b1, cur_op != OP_START);
                    return 1'b0;
                end
                SEG_SECOND:
                begin
                    if (cur_op == OP_START)
                        scl = 1'b0;
                    return 1'b1;
                end
                SEG_HIGH:
                begin
                    // ack clock of a write, after the last data bit: ack sampled, SCL dropped at once
                    if (cur_op == OP_WRITE && bit_cnt >= BITS_PER_BYTE)
                    begin
                        ack = sda_in;
                        scl = 1'b0;
                        return 1'b1;
                    end
                    if (cur_op == OP_READ)
                        shreg = {shreg[6:0], sda_in};
                    if (cur_op == OP_RACK)
                        ack = sda_in;
                    load_segment(SEG_LOW, 1'b0, sda);
                    return 1'b0;
                end
                SEG_LOW:
                begin
                    if (cur_op == OP_WRITE)
                    begin
                        bit_cnt = bit_cnt + 4'd1;
                        if (bit_cnt < BITS_PER_BYTE)
                        begin
                            load_segment(SEG_HIGH, 1'b1, shreg[7]);
                            shreg = shreg << 1;
                        end
                        else
                            load_segment(SEG_HIGH, 1'b1, 1'b1);
                        return 1'b0;
                    end
                    if (cur_op == OP_READ)
                    begin
                        bit_cnt = bit_cnt + 4'd1;
                        if (bit_cnt < BITS_PER_BYTE)
                        begin
                            load_segment(SEG_HIGH, 1'b1, 1'b1);
                            return 1'b0;
                        end
                        rx_hold = shreg;
                        return 1'b1;
                    end
                    return 1'b1;
                end
                default: return 1'b1;
            endcase
        endfunction

        function void note_input(bus_tick_t t);
            bus_levels_t r;
            bit          fin;
            fin = 1'b0;
            if (seg == SEG_IDLE)
            begin
                if (t.cmd_valid && t.op <= OP_RACK)
                begin
                    cur_op  = t.op;
                    bit_cnt = '0;
                    case (t.op)
                        OP_START: load_segment(SEG_FIRST, 1'b1, 1'b1);
                        OP_STOP:  load_segment(SEG_FIRST, 1'b1, 1'b0);
                        OP_WRITE:
                        begin
                            load_segment(SEG_HIGH, 1'b1, t.tx_byte[7]);
                            shreg = t.tx_byte << 1;
                        end
                        OP_READ:
                        begin
                            shreg = '0;
                            load_segment(SEG_HIGH, 1'b1, 1'b1);
                        end
                        OP_SACK:  load_segment(SEG_HIGH, 1'b1, t.ack_to_send);
                        default:  load_segment(SEG_HIGH, 1'b1, 1'b1);
                    endcase
                end
            end
            else
            begin
                dcount = dcount - 8'd1;
                if (dcount == 8'd0)
                    fin = close_segment(t.sda_in);
                if (fin)
                    seg = SEG_IDLE;
            end
            r.scl     = scl;
            r.sda_rel = sda;
            r.busy    = (seg != SEG_IDLE);
            r.done    = fin;
            r.rx_byte = rx_hold;
            r.rx_ack  = ack;
            levels_q.push_back(r);
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] d);
            bus_levels_t got;
            bus_levels_t exp_lv;
            got.scl     = d[OUT_SCL_BIT];
            got.sda_rel = d[OUT_SDA_BIT];
            got.busy    = d[OUT_BUSY_BIT];
            got.done    = d[OUT_DONE_BIT];
            got.rx_byte = d[OUT_RX_LSB +: 8];
            got.rx_ack  = d[OUT_ACK_BIT];
            if (levels_q.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("ERROR: result item %h with nothing pending", d);
                return;
            end
            exp_lv = levels_q.pop_front();
            if (got !== exp_lv)
            begin
                failures++;
                if (failures <= 10)
                    $display("ERROR: exp scl=%b sda=%b busy=%b done=%b rx=%h ack=%b, got %s",
                             exp_lv.scl, exp_lv.sda_rel, exp_lv.busy, exp_lv.done,
                             exp_lv.rx_byte, exp_lv.rx_ack,
                             $sformatf("scl=%b sda=%b busy=%b done=%b rx=%h ack=%b",
                                       got.scl, got.sda_rel, got.busy, got.done,
                                       got.rx_byte, got.rx_ack));
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;  // tx_byte[7:0], ack_to_send[8], sda_in[9]
    logic [IN_USER_W-1:0]  s_tuser;  // cmd_valid[0], op[3:1]
    logic                  m_tvalid;
    logic                  m_tready;
    // scl_level[0], sda_release[1], busy_res[2], done_res[3], rx_byte[11:4], rx_ack[12]
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [7:0]            cfg_data;

    bus_scoreboard sb = new();
    logic [2:0]    op_script[$];
    int            send_gap_pct;
    int            ready_stall_pct;

    i2c_master_bit_engine u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("i2c_master_bit_engine_tb NOT OK");
        $finish;
    end

    // result side: random stall bursts
    initial
    begin
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (ready_stall_pct > 0 && $urandom_range(0, 99) < ready_stall_pct)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    function automatic logic line_level(sda_mode_t mode);
        case (mode)
            SDA_LOW:  return 1'b0;
            SDA_HIGH: return 1'b1;
            default:  return 1'($urandom_range(0, 1));
        endcase
    endfunction

    function automatic bus_tick_t filler_tick(bit cmd);
        bus_tick_t t;
        t.cmd_valid   = cmd;
        t.op          = 3'($urandom_range(0, 7));
        t.tx_byte     = 8'($urandom_range(0, 255));
        t.ack_to_send = 1'($urandom_range(0, 1));
        t.sda_in      = 1'($urandom_range(0, 1));
        return t;
    endfunction

    // typical transfer: start, address, some data phases or repeated starts, stop
    function automatic void refill_script();
        op_script.push_back(OP_START);
        op_script.push_back(OP_WRITE);
        repeat ($urandom_range(0, 3))
        begin
            case ($urandom_range(0, 3))
                0: op_script.push_back(OP_WRITE);
                1:
                begin
                    op_script.push_back(OP_READ);
                    op_script.push_back(OP_SACK);
                end
                2:
                begin
                    op_script.push_back(OP_WRITE);
                    op_script.push_back(OP_RACK);
                end
                default: op_script.push_back(OP_START);
            endcase
        end
        op_script.push_back(OP_STOP);
    endfunction

    task automatic send_tick(bus_tick_t t);
        logic [IN_DATA_W-1:0] d;
        d        = '0;
        d[7:0]   = t.tx_byte;
        d[8]     = t.ack_to_send;
        d[9]     = t.sda_in;
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= {t.op, t.cmd_valid};
        do @(posedge clk); while (!s_tready);
        sb.note_input(t);
        if (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    // one command, then ticks until the sequencer is back to idle
    task automatic issue_cmd(logic [2:0] op, logic [7:0] tx, logic ack,
                             sda_mode_t mode, bit busy_noise);
        bus_tick_t t;
        t             = filler_tick(1'b1);
        t.op          = op;
        t.tx_byte     = tx;
        t.ack_to_send = ack;
        t.sda_in      = line_level(mode);
        send_tick(t);
        while (!sb.is_idle())
        begin
            t        = filler_tick(busy_noise);
            t.sda_in = line_level(mode);
            send_tick(t);
        end
    endtask

    // finish the bus command, stop sending and let every result drain
    task automatic settle_bus();
        while (!sb.is_idle())
            send_tick(filler_tick(1'b0));
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_half_period(logic [7:0] v);
        settle_bus();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.half_period = v;
    endtask

    task automatic random_traffic(int n_items);
        int        counted;
        bus_tick_t t;
        bit        counts;
        counted = 0;
        while (counted < n_items)
        begin
            if (sb.is_idle())
            begin
                if ($urandom_range(0, 99) < 80)
                begin
                    if (op_script.size() < 2)
                        refill_script();
                    // now and then skip a step of the transfer
                    if ($urandom_range(0, 99) < 5)
                        void'(op_script.pop_front());
                    t    = filler_tick(1'b1);
                    t.op = op_script.pop_front();
                end
                else
                    t = filler_tick(1'($urandom_range(0, 1)));
            end
            else
                t = filler_tick($urandom_range(0, 99) < 10);
            counts = !sb.is_idle() || (t.cmd_valid && t.op <= OP_RACK);
            send_tick(t);
            if (counts)
                counted++;
        end
    endtask

    initial
    begin
        rst_n           <= 1'b0;
        s_tvalid        <= 1'b0;
        s_tdata         <= '0;
        s_tuser         <= '0;
        cfg_valid       <= 1'b0;
        cfg_data        <= '0;
        send_gap_pct    = 10;
        ready_stall_pct = 10;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset timing first, then every op at the shortest segment
        issue_cmd(OP_START, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
        set_half_period(8'd1);
        issue_cmd(OP_START, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
        issue_cmd(OP_WRITE, 8'hFF, 1'b0, SDA_LOW, 1'b0);
        issue_cmd(OP_WRITE, 8'h00, 1'b1, SDA_HIGH, 1'b0);
        issue_cmd(OP_WRITE, 8'hA5, 1'b0, SDA_RANDOM, 1'b1);
        issue_cmd(OP_READ, 8'h00, 1'b0, SDA_HIGH, 1'b0);
        issue_cmd(OP_READ, 8'hFF, 1'b1, SDA_LOW, 1'b0);
        issue_cmd(OP_READ, 8'h3C, 1'b0, SDA_RANDOM, 1'b1);
        issue_cmd(OP_SACK, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
        issue_cmd(OP_SACK, 8'hFF, 1'b1, SDA_RANDOM, 1'b1);
        issue_cmd(OP_RACK, 8'h00, 1'b0, SDA_LOW, 1'b0);
        issue_cmd(OP_RACK, 8'h00, 1'b1, SDA_HIGH, 1'b1);
        issue_cmd(OP_START, 8'h00, 1'b0, SDA_RANDOM, 1'b1);
        issue_cmd(OP_STOP, 8'h00, 1'b0, SDA_RANDOM, 1'b1);
        issue_cmd(OP_BAD_LO, 8'hFF, 1'b1, SDA_RANDOM, 1'b0);
        issue_cmd(OP_BAD_HI, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
        send_tick(filler_tick(1'b0));
        // zero half period behaves as one tick
        set_half_period(8'd0);
        issue_cmd(OP_START, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
        issue_cmd(OP_WRITE, 8'h5A, 1'b0, SDA_RANDOM, 1'b1);
        issue_cmd(OP_STOP, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
        set_half_period(8'd255);
        issue_cmd(OP_START, 8'h00, 1'b0, SDA_RANDOM, 1'b1);

        // random transfers over several timings
        set_half_period(8'd1);
        send_gap_pct    = 20;
        ready_stall_pct = 20;
        random_traffic(60);
        set_half_period(8'd2);
        send_gap_pct    = 0;
        ready_stall_pct = 30;
        random_traffic(50);
        set_half_period(8'($urandom_range(3, 12)));
        send_gap_pct    = 15;
        ready_stall_pct = 15;
        random_traffic(60);
        set_half_period(8'd1);
        send_gap_pct    = 40;
        ready_stall_pct = 0;
        random_traffic(50);
        set_half_period(8'($urandom_range(1, 4)));
        send_gap_pct    = 0;
        ready_stall_pct = 0;
        random_traffic(60);

        settle_bus();
        if (sb.failures == 0 && sb.pending() == 0)
            $display("i2c_master_bit_engine_tb OK");
        else
            $display("i2c_master_bit_engine_tb NOT OK");
        $finish;
    end

endmodule
